@@ hw/rtl/nnfd_pkg.sv @@
// Shared types, constants and configuration indexes for the fit downscaler.
package nnfd_pkg;

  localparam int unsigned MaxDim = 4096;
  localparam int unsigned DimW   = 13;
  localparam int unsigned CntW   = 12;
  localparam int unsigned PixW   = 32;
  localparam int unsigned IdxW   = 2;

  localparam logic [IdxW-1:0] RegSrcWidth  = 2'd0;
  localparam logic [IdxW-1:0] RegSrcHeight = 2'd1;
  localparam logic [IdxW-1:0] RegTarget    = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic restart;     // clear all counts
    logic setup_start; // reset output counts, set the long fitted side to the clamped target
    logic div_start;   // start a division with selected operands
    logic [1:0] div_sel; // operand selection
    logic div_capture; // capture quotient into selected target
    logic pixel_take;  // process one pixel
  } cmd_t;

  localparam logic [1:0] SelFitH = 2'd0; // t*h/w
  localparam logic [1:0] SelFitW = 2'd1; // t*w/h
  localparam logic [1:0] SelCol  = 2'd2; // next source column
  localparam logic [1:0] SelRow  = 2'd3; // next source row

  typedef struct packed {
    logic dims_zero;   // a source side is zero
    logic fit_done;    // fitted sizes valid for the current frame
    logic wide;        // source wider than tall
    logic div_busy;
    logic need_col;    // a new column pick is pending
    logic need_row;    // a new row pick is pending
  } status_t;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
    return (v > DimW'(MaxDim)) ? DimW'(MaxDim) : v;
  endfunction

endpackage

@@ hw/rtl/nearest_neighbor_fit_downscaler_unit.sv @@
// Top level of the nearest-neighbour fit downscaler.
// Channels: cfg (index, data) writes source width, source height, target size;
// a write to one of these restarts the frame. Pixels enter on in_valid_i/in_ready_o
// in raster order; selected pixels leave on out_valid_o/out_ready_i with output
// column, row and a last-of-frame flag in the cycle after the accepting transfer.
// Throughput: at frame start the fitted side is found by a 26-step serial
// divide before the first pixel is taken. After each emitted pixel the next
// sample column (and on a row wrap also the row) is computed by the same
// divider; skipped pixels go at one per cycle while the output is free.
// Pass-through frames run at one pixel per cycle after setup while the
// receiver is ready. The output register holds one result; while the
// receiver stalls with a result waiting, no new pixel is taken.
// Reset clears sizes, counts and the output valid; nothing is emitted until
// sizes are set.
module nearest_neighbor_fit_downscaler_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [nnfd_pkg::IdxW-1:0]     cfg_index_i,
  input  logic [nnfd_pkg::DimW-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [nnfd_pkg::PixW-1:0]     pixel_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [nnfd_pkg::PixW-1:0]     pixel_out_o,
  output logic [nnfd_pkg::CntW-1:0]     out_column_o,
  output logic [nnfd_pkg::CntW-1:0]     out_row_o,
  output logic                          frame_last_o
);
  nnfd_pkg::cmd_t    cmd;
  nnfd_pkg::status_t status;
  logic cfg_we;
  logic cfg_known;
  logic out_free;

  assign cfg_ready_o = 1'b1;
  assign cfg_we = cfg_valid_i;
  // unmapped indexes are ignored and leave the frame running
  assign cfg_known = cfg_index_i <= nnfd_pkg::RegTarget;
  assign out_free = !out_valid_o || out_ready_i;

  nnfd_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .cfg_we_i   (cfg_we),
    .cfg_known_i(cfg_known),
    .in_valid_i,
    .in_ready_o,
    .out_free_i (out_free),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  nnfd_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i     (cmd),
    .status_o  (status),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_index_i),
    .cfg_data_i,
    .pixel_in_i,
    .out_ready_i,
    .out_valid_o,
    .pixel_out_o,
    .out_column_o,
    .out_row_o,
    .frame_last_o
  );
endmodule

@@ hw/rtl/nnfd_divider.sv @@
// Restoring divider, one quotient bit per cycle, for fitted sizes and sampling positions.
module nnfd_divider (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [2*nnfd_pkg::DimW-1:0]    dividend_i,
  input  logic [nnfd_pkg::DimW-1:0]      divisor_i,
  output logic                           busy_o,
  output logic [2*nnfd_pkg::DimW-1:0]    quot_o
);
  localparam int unsigned NW = 2 * nnfd_pkg::DimW;
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] quot_q, quot_d;
  logic [nnfd_pkg::DimW:0] rem_q, rem_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic [nnfd_pkg::DimW-1:0] dvs_q, dvs_d;
  logic [nnfd_pkg::DimW:0] trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    dvs_d  = dvs_q;
    trial  = {rem_q[nnfd_pkg::DimW-1:0], quot_q[NW-1]};
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CW'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d  = trial - {1'b0, dvs_q};
        quot_d = {quot_q[NW-2:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
endmodule

@@ hw/rtl/nnfd_datapath.sv @@
// Counters, fitted sizes, divider operand selection and output register.
module nnfd_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  nnfd_pkg::cmd_t                cmd_i,
  output nnfd_pkg::status_t             status_o,
  input  logic                          cfg_we_i,
  input  logic [nnfd_pkg::IdxW-1:0]     cfg_idx_i,
  input  logic [nnfd_pkg::DimW-1:0]     cfg_data_i,
  input  logic [nnfd_pkg::PixW-1:0]     pixel_in_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [nnfd_pkg::PixW-1:0]     pixel_out_o,
  output logic [nnfd_pkg::CntW-1:0]     out_column_o,
  output logic [nnfd_pkg::CntW-1:0]     out_row_o,
  output logic                          frame_last_o
);
  localparam int unsigned DW = nnfd_pkg::DimW;
  localparam int unsigned CW = nnfd_pkg::CntW;

  logic [DW-1:0] sw_q, sh_q, ts_q;
  logic [DW-1:0] w, h, t;
  logic [DW-1:0] fw_q, fh_q;
  logic          pt_q;
  logic          fit_done_q;
  logic [DW-1:0] scol_q, srow_q, ocol_q, orow_q, ncol_q, nrow_q;
  logic          need_col_q, need_row_q;
  logic [2*DW-1:0] dvd;
  logic [DW-1:0]   dvs;
  logic            div_busy;
  logic [2*DW-1:0] quot;
  logic [DW-1:0]   quot_c;
  logic            ov_q;
  logic [nnfd_pkg::PixW-1:0] pix_q;
  logic [CW-1:0] oc_q, orr_q;
  logic          last_q;

  assign w = nnfd_pkg::clamp_dim(sw_q);
  assign h = nnfd_pkg::clamp_dim(sh_q);
  assign t = nnfd_pkg::clamp_dim(ts_q);

  always_comb begin
    unique case (cmd_i.div_sel)
      nnfd_pkg::SelFitH: begin dvd = (2*DW)'(t) * (2*DW)'(h);      dvs = w; end
      nnfd_pkg::SelFitW: begin dvd = (2*DW)'(t) * (2*DW)'(w);      dvs = h; end
      nnfd_pkg::SelCol:  begin dvd = (2*DW)'(ocol_q) * (2*DW)'(w); dvs = fw_q; end
      default:           begin dvd = (2*DW)'(orow_q) * (2*DW)'(h); dvs = fh_q; end
    endcase
  end

  nnfd_divider u_div (
    .clk_i, .rst_ni,
    .start_i   (cmd_i.div_start),
    .dividend_i(dvd),
    .divisor_i (dvs),
    .busy_o    (div_busy),
    .quot_o    (quot)
  );
  assign quot_c = quot[DW-1:0];

  // match against the pending sample point
  logic hit, emit, col_wrap, row_wrap;
  logic [DW-1:0] ocol_inc;
  assign hit = (fw_q != '0) && (fh_q != '0) && (orow_q < fh_q) && (ocol_q < fw_q)
               && (srow_q == nrow_q) && (scol_q == ncol_q);
  assign emit = pt_q || hit;
  assign ocol_inc = ocol_q + 1'b1;
  assign col_wrap = (scol_q + 1'b1) >= w;
  assign row_wrap = (srow_q + 1'b1) >= h;

  logic [DW-1:0] fw_new, fh_new;
  always_comb begin
    fw_new = fw_q;
    fh_new = fh_q;
    if (w > h) fh_new = quot_c; else fw_new = quot_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q <= '0; sh_q <= '0; ts_q <= '0;
      fw_q <= '0; fh_q <= '0; pt_q <= 1'b0;
      fit_done_q <= 1'b0;
      scol_q <= '0; srow_q <= '0; ocol_q <= '0; orow_q <= '0;
      ncol_q <= '0; nrow_q <= '0;
      need_col_q <= 1'b0; need_row_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (cmd_i.pixel_take) ov_q <= emit;
      else if (out_valid_o && out_ready_i) ov_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          nnfd_pkg::RegSrcWidth:  sw_q <= cfg_data_i;
          nnfd_pkg::RegSrcHeight: sh_q <= cfg_data_i;
          nnfd_pkg::RegTarget:    ts_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.restart) begin
        scol_q <= '0; srow_q <= '0; ocol_q <= '0; orow_q <= '0;
        ncol_q <= '0; nrow_q <= '0;
        need_col_q <= 1'b0; need_row_q <= 1'b0;
        fit_done_q <= 1'b0;
      end
      if (cmd_i.setup_start) begin
        ocol_q <= '0; orow_q <= '0; ncol_q <= '0; nrow_q <= '0;
        need_col_q <= 1'b0; need_row_q <= 1'b0;
        fit_done_q <= 1'b0;
        if (t == '0) begin
          fw_q <= '0; fh_q <= '0; pt_q <= 1'b0;
        end else if (w > h) begin
          fw_q <= t;
        end else begin
          fh_q <= t;
        end
      end
      if (cmd_i.div_capture) begin
        unique case (cmd_i.div_sel)
          nnfd_pkg::SelFitH, nnfd_pkg::SelFitW: begin
            fw_q <= fw_new; fh_q <= fh_new;
            pt_q <= (fw_new >= w) && (fh_new >= h);
            fit_done_q <= 1'b1;
          end
          nnfd_pkg::SelCol: begin ncol_q <= quot_c; need_col_q <= 1'b0; end
          default:          begin nrow_q <= quot_c; need_row_q <= 1'b0; end
        endcase
      end
      if (cmd_i.pixel_take) begin
        if (!pt_q && hit) begin
          if (ocol_inc >= fw_q) begin
            ocol_q <= '0;
            orow_q <= orow_q + 1'b1;
            need_row_q <= 1'b1;
          end else begin
            ocol_q <= ocol_inc;
          end
          need_col_q <= 1'b1;
        end
        if (col_wrap) begin
          scol_q <= '0;
          srow_q <= row_wrap ? '0 : srow_q + 1'b1;
          // last source pixel: the next one starts a new frame
          if (row_wrap) fit_done_q <= 1'b0;
        end else begin
          scol_q <= scol_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pixel_take && emit) begin
      pix_q <= pixel_in_i;
      if (pt_q) begin
        oc_q <= scol_q[CW-1:0];
        orr_q <= srow_q[CW-1:0];
        last_q <= (scol_q == w - 1'b1) && (srow_q == h - 1'b1);
      end else begin
        oc_q <= ocol_q[CW-1:0];
        orr_q <= orow_q[CW-1:0];
        last_q <= (ocol_q == fw_q - 1'b1) && (orow_q == fh_q - 1'b1);
      end
    end
  end

  assign status_o.dims_zero   = (w == '0) || (h == '0);
  assign status_o.fit_done    = fit_done_q;
  assign status_o.wide        = w > h;
  assign status_o.div_busy    = div_busy;
  assign status_o.need_col    = need_col_q;
  assign status_o.need_row    = need_row_q;

  assign out_valid_o  = ov_q;
  assign pixel_out_o  = pix_q;
  assign out_column_o = oc_q;
  assign out_row_o    = orr_q;
  assign frame_last_o = last_q;
endmodule

@@ hw/rtl/nnfd_ctrl.sv @@
// Controller: frame setup, sample-point divisions and pixel acceptance.
module nnfd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_known_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_free_i,
  input  nnfd_pkg::status_t status_i,
  output nnfd_pkg::cmd_t    cmd_o
);
  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StFit   = 2'd1;
  localparam logic [1:0] StPick  = 2'd2;
  localparam logic [1:0] StPickW = 2'd3;

  logic [1:0] state_q, state_d;
  logic [1:0] sel_q, sel_d;
  logic ready;

  // pixel may be taken in idle, output free, no config write, frame set up and no pick pending (or a size zero)
  assign ready = (state_q == StIdle) && out_free_i && !cfg_we_i &&
                 (status_i.dims_zero || (status_i.fit_done &&
                  !status_i.need_col && !status_i.need_row));
  assign in_ready_o = ready;

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    cmd_o   = '0;
    cmd_o.div_sel = sel_q;
    if (cfg_we_i && cfg_known_i) begin
      cmd_o.restart = 1'b1;
      state_d = StIdle;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (ready && in_valid_i) begin
            cmd_o.pixel_take = !status_i.dims_zero;
            cmd_o.restart    = status_i.dims_zero;
          end else if (!status_i.dims_zero && !status_i.fit_done && in_valid_i) begin
            cmd_o.setup_start = 1'b1;
            state_d = StFit;
          end else if (status_i.need_col) begin
            sel_d = nnfd_pkg::SelCol; state_d = StPick;
          end else if (status_i.need_row) begin
            sel_d = nnfd_pkg::SelRow; state_d = StPick;
          end
        end
        StFit: begin
          // the shorter side is the one divided down
          sel_d = status_i.wide ? nnfd_pkg::SelFitH : nnfd_pkg::SelFitW;
          state_d = StPick;
        end
        StPick: begin
          cmd_o.div_start = 1'b1;
          state_d = StPickW;
        end
        StPickW: begin
          if (!status_i.div_busy) begin
            cmd_o.div_capture = 1'b1;
            state_d = StIdle;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      sel_q   <= nnfd_pkg::SelFitH;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end
endmodule

@@ hw/rtl/nnfd_checker.sv @@
// Port-level assertions for the fit downscaler, bound to the top level.
module nnfd_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic cfg_valid_i,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic [31:0] pixel_out_o,
  input logic frame_last_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_out_o))
    else $error("stalled result changed");
  a_no_take_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while result stalled");
  a_cfg_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> !in_ready_o)
    else $error("pixel taken during config write");
  a_last_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(frame_last_o))
    else $error("last flag changed");
endmodule

bind nearest_neighbor_fit_downscaler_unit nnfd_checker u_nnfd_checker (
  .clk_i, .rst_ni, .cfg_valid_i, .in_valid_i, .in_ready_o,
  .out_valid_o, .out_ready_i, .pixel_out_o, .frame_last_o
);

@@ tb/sv/nnfd_scoreboard.sv @@
// Checker for the fit downscaler: predicts sampled pixels and compares output transfers.
`timescale 1ns / 1ps
module nnfd_scoreboard (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [nnfd_pkg::IdxW-1:0] cfg_index_i,
  input  logic [nnfd_pkg::DimW-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic [nnfd_pkg::PixW-1:0] pixel_in_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic [nnfd_pkg::PixW-1:0] pixel_out_i,
  input  logic [nnfd_pkg::CntW-1:0] out_column_i,
  input  logic [nnfd_pkg::CntW-1:0] out_row_i,
  input  logic                      frame_last_i,
  output int unsigned               err_count_o,
  output int unsigned               pending_o,
  output int unsigned               result_count_o
);
  import nnfd_pkg::*;

  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic [CntW-1:0] column;
    logic [CntW-1:0] row;
    logic            last;
  } sample_t;

  sample_t sample_q[$];

  logic [DimW-1:0] src_w, src_h, tgt;
  // counts kept at 13 bits: output counts may reach a fitted side of MaxDim
  logic [DimW-1:0] src_col, src_row, dst_col, dst_row, pick_col, pick_row;
  logic [DimW-1:0] fit_w, fit_h;
  logic            bypass;

  function automatic logic [DimW-1:0] lim(input logic [DimW-1:0] v);
    return (v > DimW'(MaxDim)) ? DimW'(MaxDim) : v;
  endfunction

  function automatic logic [DimW-1:0] src_pos(input logic [DimW-1:0] pos,
                                              input logic [DimW-1:0] sdim,
                                              input logic [DimW-1:0] odim);
    logic [2*DimW-1:0] prod;
    prod = pos * sdim;
    if (odim == 0) return '0;
    return DimW'(prod / odim);
  endfunction

  task automatic clear_counts();
    src_col = 0; src_row = 0; dst_col = 0; dst_row = 0; pick_col = 0; pick_row = 0;
  endtask

  task automatic predict_pixel(input logic [PixW-1:0] pix);
    logic [DimW-1:0] w, h, t;
    logic [2*DimW-1:0] prod;
    sample_t s;
    w = lim(src_w); h = lim(src_h); t = lim(tgt);
    if (w == 0 || h == 0) begin
      clear_counts();
      return;
    end
    if (src_col == 0 && src_row == 0) begin
      if (t == 0) begin
        fit_w = 0; fit_h = 0; bypass = 1'b0;
      end else begin
        if (w > h) begin
          prod = t * h; fit_h = DimW'(prod / w); fit_w = t;
        end else begin
          prod = t * w; fit_w = DimW'(prod / h); fit_h = t;
        end
        bypass = (fit_w >= w) && (fit_h >= h);
      end
      dst_col = 0; dst_row = 0; pick_col = 0; pick_row = 0;
    end
    if (bypass) begin
      s.pixel = pix; s.column = CntW'(src_col); s.row = CntW'(src_row);
      s.last = (src_col == w - 1) && (src_row == h - 1);
      sample_q.push_back(s);
    end else if (fit_w != 0 && fit_h != 0 && dst_row < fit_h && dst_col < fit_w &&
                 src_row == pick_row && src_col == pick_col) begin
      s.pixel = pix; s.column = CntW'(dst_col); s.row = CntW'(dst_row);
      s.last = (dst_col == fit_w - 1) && (dst_row == fit_h - 1);
      sample_q.push_back(s);
      dst_col++;
      if (dst_col >= fit_w) begin
        dst_col = 0;
        dst_row++;
        pick_row = src_pos(dst_row, h, fit_h);
      end
      pick_col = src_pos(dst_col, w, fit_w);
    end
    src_col++;
    if (src_col >= w) begin
      src_col = 0;
      src_row++;
      if (src_row >= h) src_row = 0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sample_t got, want;
    if (!rst_ni) begin
      src_w = 0; src_h = 0; tgt = 0;
      fit_w = 0; fit_h = 0; bypass = 1'b0;
      clear_counts();
      sample_q.delete();
      err_count_o = 0;
      result_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = '{pixel_out_i, out_column_i, out_row_i, frame_last_i};
        result_count_o++;
        if (sample_q.size() == 0) begin
          err_count_o++;
          if (err_count_o <= 10)
            $display("%0t: unexpected output pix=%h col=%0d row=%0d last=%0b",
                     $realtime, got.pixel, got.column, got.row, got.last);
        end else begin
          want = sample_q.pop_front();
          if (got != want) begin
            err_count_o++;
            if (err_count_o <= 10)
              $display("%0t: mismatch exp pix=%h col=%0d row=%0d last=%0b, got pix=%h col=%0d row=%0d last=%0b",
                       $realtime, want.pixel, want.column, want.row, want.last,
                       got.pixel, got.column, got.row, got.last);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegSrcWidth:  begin src_w = cfg_data_i; clear_counts(); end
          RegSrcHeight: begin src_h = cfg_data_i; clear_counts(); end
          RegTarget:    begin tgt = cfg_data_i; clear_counts(); end
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) predict_pixel(pixel_in_i);
    end
    pending_o = sample_q.size();
  end

endmodule

@@ tb/sv/nearest_neighbor_fit_downscaler_unit_tb.sv @@
// Testbench top for the fit downscaler: stimulus, stall patterns, watchdog and verdict.
`timescale 1ns / 1ps
module nearest_neighbor_fit_downscaler_unit_tb;
  import nnfd_pkg::*;

  localparam logic [IdxW-1:0] RegSpare = 2'd3;  // unmapped index, must be ignored
  localparam int unsigned StallLimit = 20000;
  localparam int unsigned SettleCycles = 80;
  localparam int unsigned ItemTarget = 1600;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0, cfg_ready_o;
  logic [IdxW-1:0] cfg_index_i = '0;
  logic [DimW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0, in_ready_o;
  logic [PixW-1:0] pixel_in_i = '0;
  logic out_valid_o, out_ready_i = 1'b0;
  logic [PixW-1:0] pixel_out_o;
  logic [CntW-1:0] out_column_o, out_row_o;
  logic frame_last_o;

  int unsigned err_count, pending, result_count;
  int unsigned pixels_sent, frames_set, idle_cycles;
  logic hold_req = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  nearest_neighbor_fit_downscaler_unit u_dut (.*);

  nnfd_scoreboard u_scoreboard (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .pixel_in_i,
    .out_valid_i(out_valid_o), .out_ready_i, .pixel_out_i(pixel_out_o),
    .out_column_i(out_column_o), .out_row_i(out_row_o), .frame_last_i(frame_last_o),
    .err_count_o(err_count), .pending_o(pending), .result_count_o(result_count)
  );

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // receiver: bursts of ready, random stalls, one long hold-off on request
  initial begin
    int unsigned n;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(50, 1)) @(posedge clk_i);
      n = gap_len();
      if (n != 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && in_ready_o) ||
        (out_valid_o && out_ready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("watchdog: no transfer for %0d cycles, %0d results pending", idle_cycles, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [DimW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // waits out outstanding samples and any divide still running
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_sizes(input logic [DimW-1:0] w, input logic [DimW-1:0] h,
                           input logic [DimW-1:0] t);
    drain();
    write_reg(RegSrcWidth, w);
    write_reg(RegSrcHeight, h);
    write_reg(RegTarget, t);
    frames_set++;
  endtask

  task automatic send_pixel(input logic [PixW-1:0] pix, input int unsigned gap);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_in_i <= pix;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    pixels_sent++;
  endtask

  task automatic send_random(input int unsigned n);
    repeat (n) send_pixel($urandom, gap_len());
  endtask

  initial begin
    int unsigned w, h, t, n, sel;
    pixels_sent = 0;
    frames_set = 0;
    idle_cycles = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: sizes still zero, pixels are dropped
    send_pixel(32'h0000_0000, 0);
    send_pixel(32'hFFFF_FFFF, 0);
    // landscape shrink 4x2 -> 2x1
    set_sizes(4, 2, 2);
    send_pixel(32'hFFFF_FFFF, 0);
    send_pixel(32'h0000_0000, 0);
    send_pixel(32'hAAAA_5555, 0);
    send_pixel(32'h5555_AAAA, 0);
    send_random(4);
    // square source, target larger: pass through
    set_sizes(3, 3, 8);
    send_random(5);
    // write abandons the frame mid-way, spare index is ignored
    drain();
    write_reg(RegSpare, 13'h1FFF);
    write_reg(RegTarget, 2);
    send_random(4);
    // zero target: counted, nothing emitted
    set_sizes(2, 3, 0);
    send_random(3);
    // oversized registers clamp to the maximum
    set_sizes(13'h1FFF, 2, 13'h1FFF);
    send_random(3);

    // long receiver hold-off on a pass-through frame so the output backs up
    set_sizes(6, 5, 10);
    hold_req = 1'b1;
    wait (!hold_req);
    repeat (60) send_pixel($urandom, 0);

    while (pixels_sent < ItemTarget) begin
      sel = $urandom_range(99);
      if (sel < 70) begin
        w = $urandom_range(12, 1); h = $urandom_range(12, 1); t = $urandom_range(16, 1);
        n = $urandom_range(3, 1) * w * h + $urandom_range(w * h - 1);
      end else if (sel < 78) begin
        w = $urandom_range(1) ? 0 : $urandom_range(8, 1);
        h = (w == 0) ? $urandom_range(8) : 0;
        t = $urandom_range(8191);
        n = $urandom_range(10, 1);
      end else if (sel < 84) begin
        w = $urandom_range(10, 1); h = $urandom_range(10, 1); t = 0;
        n = w * h + $urandom_range(5);
      end else if (sel < 94) begin
        w = $urandom_range(8191, 1000); h = $urandom_range(2, 1); t = $urandom_range(8, 1);
        n = $urandom_range(300, 50);
      end else begin
        w = 4096; h = 4096; t = $urandom_range(1) ? 4096 : 8191;
        n = $urandom_range(40, 10);
      end
      if (n > ItemTarget - pixels_sent) n = ItemTarget - pixels_sent;
      set_sizes(DimW'(w), DimW'(h), DimW'(t));
      send_random(n);
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("%0d pixels in %0d size settings, %0d sampled pixels checked",
             pixels_sent, frames_set, result_count);
    $display("covered shrink, pass-through, zero sizes, zero target, clamping, output back-pressure");
    if (err_count == 0 && pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

@@ nearest_neighbor_fit_downscaler_unit.f @@
hw/rtl/nnfd_pkg.sv
hw/rtl/nnfd_divider.sv
hw/rtl/nnfd_datapath.sv
hw/rtl/nnfd_ctrl.sv
hw/rtl/nearest_neighbor_fit_downscaler_unit.sv
hw/rtl/nnfd_checker.sv
tb/sv/nnfd_scoreboard.sv
tb/sv/nearest_neighbor_fit_downscaler_unit_tb.sv
